// ===== hdl/pta_pkg.sv =====
package pta_pkg;

  // primitive type codes
  localparam logic [3:0] PRIM_POINTS     = 4'd0;
  localparam logic [3:0] PRIM_LINES      = 4'd1;
  localparam logic [3:0] PRIM_TRIANGLES  = 4'd4;
  localparam logic [3:0] PRIM_TRI_STRIP  = 4'd5;
  localparam logic [3:0] PRIM_TRI_FAN    = 4'd6;
  localparam logic [3:0] PRIM_QUADS      = 4'd7;
  localparam logic [3:0] PRIM_QUAD_STRIP = 4'd8;
  localparam logic [3:0] PRIM_POLYGON    = 4'd9;

  localparam int TYPE_BITS  = 4;
  localparam int CORNERS    = 3;
  localparam int TRI_BITS   = 32;
  localparam int TUSER_BITS = TYPE_BITS + 1;

  localparam int LOCAL_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 24;

  // corner slot indices
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  typedef struct packed {
    logic             first;
    logic [TYPE_BITS-1:0] prim_type;
  } vtx_ctrl_t;

endpackage

// ===== hdl/pta_assembler.sv =====
module pta_assembler
  import pta_pkg::*;
#(
  parameter int LOCAL_BITS = LOCAL_BITS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  vtx_ctrl_t             ctrl,
  input  logic [POS_BITS-1:0]   pos,
  output logic                  emit,
  output logic [TRI_BITS-1:0]   tri_num,
  output logic [LOCAL_BITS-1:0] loc_a,
  output logic [LOCAL_BITS-1:0] loc_b,
  output logic [LOCAL_BITS-1:0] loc_c,
  output logic [POS_BITS-1:0]   pos_a,
  output logic [POS_BITS-1:0]   pos_b,
  output logic [POS_BITS-1:0]   pos_c
);

  logic [LOCAL_BITS-1:0] sl_r   [CORNERS];
  logic [POS_BITS-1:0]   sp_r   [CORNERS];
  logic [LOCAL_BITS-1:0] sl_nxt [CORNERS];
  logic [POS_BITS-1:0]   sp_nxt [CORNERS];
  logic [LOCAL_BITS-1:0] vcnt_r, vcnt_nxt;
  logic [1:0]            ph3_r, ph3_nxt;
  logic [TRI_BITS-1:0]   tcnt_r;
  logic [TYPE_BITS-1:0]  cur_r, cur_nxt;

  logic [LOCAL_BITS-1:0] v;
  logic [1:0]            ph;
  logic                  v_small;
  logic                  emit_c;

  always_comb begin
    cur_nxt = ctrl.first ? ctrl.prim_type : cur_r;
    v       = ctrl.first ? '0 : vcnt_r;
    ph      = ctrl.first ? SLOT_A : ph3_r;
    v_small = (v < LOCAL_BITS'(3));
    vcnt_nxt = v + LOCAL_BITS'(1);
    // phase of v mod 3 restarts when the vertex count wraps
    if (&v || ph == SLOT_C) ph3_nxt = SLOT_A;
    else ph3_nxt = ph + 2'd1;

    for (int k = 0; k < CORNERS; k++) begin
      sl_nxt[k] = sl_r[k];
      sp_nxt[k] = sp_r[k];
    end
    emit_c = 1'b0;

    case (cur_nxt)
      PRIM_TRIANGLES: begin
        sl_nxt[ph] = v;
        sp_nxt[ph] = pos;
        emit_c = (ph == SLOT_C);
      end
      PRIM_QUADS: begin
        if (v[1:0] != 2'd3) begin
          sl_nxt[v[1:0]] = v;
          sp_nxt[v[1:0]] = pos;
          emit_c = (v[1:0] == SLOT_C);
        end else begin
          sl_nxt[SLOT_B] = sl_r[SLOT_C];
          sp_nxt[SLOT_B] = sp_r[SLOT_C];
          sl_nxt[SLOT_C] = v;
          sp_nxt[SLOT_C] = pos;
          emit_c = 1'b1;
        end
      end
      PRIM_TRI_STRIP, PRIM_QUAD_STRIP: begin
        if (v_small) begin
          sl_nxt[v[1:0]] = v;
          sp_nxt[v[1:0]] = pos;
          emit_c = (v[1:0] == SLOT_C);
        end else begin
          // alternate winding: odd vertex replaces corner A, even replaces B
          if (v[0]) begin
            sl_nxt[SLOT_A] = sl_r[SLOT_C];
            sp_nxt[SLOT_A] = sp_r[SLOT_C];
          end else begin
            sl_nxt[SLOT_B] = sl_r[SLOT_C];
            sp_nxt[SLOT_B] = sp_r[SLOT_C];
          end
          sl_nxt[SLOT_C] = v;
          sp_nxt[SLOT_C] = pos;
          // drop degenerate triangles
          emit_c = !(sp_nxt[SLOT_A] == sp_nxt[SLOT_B] ||
                     sp_nxt[SLOT_A] == sp_nxt[SLOT_C] ||
                     sp_nxt[SLOT_B] == sp_nxt[SLOT_C]);
        end
      end
      PRIM_TRI_FAN, PRIM_POLYGON: begin
        if (v_small) begin
          sl_nxt[v[1:0]] = v;
          sp_nxt[v[1:0]] = pos;
          emit_c = (v[1:0] == SLOT_C);
        end else begin
          sl_nxt[SLOT_B] = sl_r[SLOT_C];
          sp_nxt[SLOT_B] = sp_r[SLOT_C];
          sl_nxt[SLOT_C] = v;
          sp_nxt[SLOT_C] = pos;
          emit_c = 1'b1;
        end
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORNERS; k++) begin
        sl_r[k] <= '0;
        sp_r[k] <= '0;
      end
      vcnt_r <= '0;
      ph3_r  <= SLOT_A;
      tcnt_r <= '0;
      cur_r  <= PRIM_POINTS;
    end else if (go) begin
      for (int k = 0; k < CORNERS; k++) begin
        sl_r[k] <= sl_nxt[k];
        sp_r[k] <= sp_nxt[k];
      end
      vcnt_r <= vcnt_nxt;
      ph3_r  <= ph3_nxt;
      cur_r  <= cur_nxt;
      if (emit_c) tcnt_r <= tcnt_r + TRI_BITS'(1);
    end
  end

  assign emit    = emit_c;
  assign tri_num = tcnt_r;
  assign loc_a   = sl_nxt[SLOT_A];
  assign loc_b   = sl_nxt[SLOT_B];
  assign loc_c   = sl_nxt[SLOT_C];
  assign pos_a   = sp_nxt[SLOT_A];
  assign pos_b   = sp_nxt[SLOT_B];
  assign pos_c   = sp_nxt[SLOT_C];

  a_tcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    go && emit_c |=> tcnt_r == $past(tcnt_r) + TRI_BITS'(1))
    else $error("triangle number did not advance on emit");

  a_vcnt_first: assert property (@(posedge clk) disable iff (!rst_n)
    go && ctrl.first |=> vcnt_r == LOCAL_BITS'(1))
    else $error("vertex count not restarted on primitive start");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph3_r != 2'd3)
    else $error("triangle phase out of range");

endmodule

// ===== hdl/primitive_triangle_assembler_top.sv =====
// Triangle assembler: takes one vertex per clock (position index in tdata,
// primitive type and first-of-primitive flag in tuser) and emits at most one
// triangle per vertex with its running number, local vertex numbers and
// position indices. A vertex passes an input register, the triangulation
// logic and an output register, which holds each result on out_tvalid
// until it is taken. One vertex is taken every cycle while the output
// side keeps up; the output register stall is the only thing that holds
// the input. Points, lines, unknown codes, short primitives, incomplete
// trailing triangles, trailing quads of fewer than three vertices, and
// degenerate strip triangles emit nothing.
module primitive_triangle_assembler_top
  import pta_pkg::*;
#(
  parameter int LOCAL_BITS = LOCAL_BITS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF,
  localparam int IN_DW     = ((POS_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W = TRI_BITS + 3 * LOCAL_BITS + 3 * POS_BITS,
  localparam int OUT_DW    = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DW-1:0]      in_tdata,   // position_index
  input  logic [TUSER_BITS-1:0] in_tuser,   // prim_type, first_of_prim
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata   // triangle_number, local_a, local_b,
                                            // local_c, pos_a, pos_b, pos_c
);

  logic                  s1_valid_r;
  vtx_ctrl_t             s1_ctrl_r;
  logic [POS_BITS-1:0]   s1_pos_r;
  logic                  out_valid_r;
  logic [OUT_RAW_W-1:0]  out_data_r, out_data_nxt;

  logic                  adv, go, emit;
  logic [TRI_BITS-1:0]   tri_num;
  logic [LOCAL_BITS-1:0] loc_a, loc_b, loc_c;
  logic [POS_BITS-1:0]   pos_a, pos_b, pos_c;

  assign adv       = !out_valid_r || out_tready;
  assign go        = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ctrl_r.prim_type <= in_tuser[TYPE_BITS-1:0];
      s1_ctrl_r.first     <= in_tuser[TYPE_BITS];
      s1_pos_r            <= in_tdata[POS_BITS-1:0];
    end
  end

  pta_assembler #(
    .LOCAL_BITS (LOCAL_BITS),
    .POS_BITS   (POS_BITS)
  ) u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .ctrl    (s1_ctrl_r),
    .pos     (s1_pos_r),
    .emit    (emit),
    .tri_num (tri_num),
    .loc_a   (loc_a),
    .loc_b   (loc_b),
    .loc_c   (loc_c),
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .pos_c   (pos_c)
  );

  assign out_data_nxt = {pos_c, pos_b, pos_a, loc_c, loc_b, loc_a, tri_num};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && go && emit) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled request lost");

  a_newest_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_data_r[TRI_BITS+3*LOCAL_BITS-1 -: LOCAL_BITS] >
        out_data_r[TRI_BITS+LOCAL_BITS-1 -: LOCAL_BITS] &&
      out_data_r[TRI_BITS+3*LOCAL_BITS-1 -: LOCAL_BITS] >
        out_data_r[TRI_BITS+2*LOCAL_BITS-1 -: LOCAL_BITS])
    else $error("third corner is not the newest vertex");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r && !out_valid_r |=> !out_valid_r)
    else $error("result without a vertex");

endmodule
